// File: rtl/core/totq_pkg.sv
// ---------------------------------------------------------------------------
// Turn queue package
// Shared constants, field types, operation and status codes, and the
// storage request bundle for the ticks-ordered turn queue.
// ---------------------------------------------------------------------------
package totq_pkg;

    // Capacity and derived widths
    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Beat field widths
    localparam int MODE_W   = 3;
    localparam int ID_W     = 16;
    localparam int TICKS_W  = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = ID_W + TICKS_W;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [TICKS_W-1:0]  ticks_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [CNT_W-1:0]    held_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [ENTRY_W-1:0]  entry_t;

    // Operation codes
    localparam mode_t MODE_INSERT  = 3'd0;
    localparam mode_t MODE_REMOVE  = 3'd1;
    localparam mode_t MODE_POP     = 3'd2;
    localparam mode_t MODE_PEEK    = 3'd3;
    localparam mode_t MODE_ADVANCE = 3'd4;

    // Status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_FULL      = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_NOT_DUE   = 3'd4;

    // Slot store access bundle: one write and one read port
    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        logic   re;
        addr_t  raddr;
    } ram_req_t;

endpackage

// File: rtl/core/totq_cmd_if.sv
// ---------------------------------------------------------------------------
// Turn queue command channel
// Valid/ready channel carrying one operation beat into the queue.
// ---------------------------------------------------------------------------
interface totq_cmd_if;

    logic              valid;
    logic              ready;
    totq_pkg::mode_t   mode;
    totq_pkg::id_t     entity_id;
    totq_pkg::ticks_t  ticks;

    modport source (output valid, output mode, output entity_id, output ticks,
                    input ready);
    modport sink   (input valid, input mode, input entity_id, input ticks,
                    output ready);

endinterface

// File: rtl/core/totq_rsp_if.sv
// ---------------------------------------------------------------------------
// Turn queue response channel
// Valid/ready channel carrying one result beat out of the queue.
// ---------------------------------------------------------------------------
interface totq_rsp_if;

    logic               valid;
    logic               ready;
    totq_pkg::id_t      head_entity;
    totq_pkg::ticks_t   advanced_ticks;
    totq_pkg::status_t  status;
    totq_pkg::count_t   entry_count;

    modport source (output valid, output head_entity, output advanced_ticks,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input head_entity, input advanced_ticks,
                    input status, input entry_count, output ready);

endinterface

// File: rtl/core/totq_ram.sv
// ---------------------------------------------------------------------------
// Turn queue slot RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ---------------------------------------------------------------------------
module totq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/totq_ctrl.sv
// ---------------------------------------------------------------------------
// Turn queue sequencer
// Walks the sorted slot RAM one entry per read/evaluate pair to insert,
// remove, pop, peek or advance, and holds the result beat register.
// ---------------------------------------------------------------------------
module totq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    totq_cmd_if.sink            cmd,
    totq_rsp_if.source          rsp,
    output totq_pkg::ram_req_t  ram_req,
    input  totq_pkg::entry_t    ram_rdata
);

    import totq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t  state_reg;
    mode_t   op_reg;
    id_t     id_reg;
    ticks_t  tk_reg;
    held_t   idx_reg;
    logic    found_reg;
    ticks_t  adv_reg;
    held_t   held_reg;
    id_t     res_head_reg;
    ticks_t  res_adv_reg;
    status_t res_status_reg;

    logic    rsp_valid_reg;
    id_t     rsp_head_reg;
    ticks_t  rsp_adv_reg;
    status_t rsp_status_reg;
    count_t  rsp_count_reg;

    id_t     rd_ent;
    ticks_t  rd_tk;
    held_t   idx_dec;
    held_t   idx_inc;
    logic    idx_zero;
    logic    last;
    logic    hit;
    ticks_t  sub;

    // Split the read word and derive walk position helpers
    assign rd_ent   = ram_rdata[ENTRY_W-1:TICKS_W];
    assign rd_tk    = ram_rdata[TICKS_W-1:0];
    assign idx_dec  = idx_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_zero = (idx_reg == '0);
    assign last     = (idx_inc == held_reg);
    assign hit      = (op_reg == MODE_REMOVE) ? (!found_reg && (rd_ent == id_reg))
                                              : idx_zero;
    assign sub      = idx_zero ? rd_tk : adv_reg;

    // Drive slot RAM accesses for the current walk step
    always_comb
    begin
        ram_req       = '0;
        ram_req.raddr = (op_reg == MODE_INSERT) ? idx_dec[ADDR_W-1:0]
                                                : idx_reg[ADDR_W-1:0];
        if (state_reg == S_READ)
        begin
            if ((op_reg == MODE_INSERT) && idx_zero)
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = {id_reg, tk_reg};
            end
            else
            begin
                ram_req.re = 1'b1;
            end
        end
        else if (state_reg == S_EVAL)
        begin
            unique case (op_reg)
                MODE_INSERT:
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_reg[ADDR_W-1:0];
                    ram_req.wdata = (rd_tk > tk_reg) ? ram_rdata : {id_reg, tk_reg};
                end
                MODE_REMOVE, MODE_POP:
                begin
                    ram_req.we    = found_reg;
                    ram_req.waddr = idx_dec[ADDR_W-1:0];
                    ram_req.wdata = ram_rdata;
                end
                MODE_ADVANCE:
                begin
                    ram_req.we    = !(idx_zero && (rd_tk == '0));
                    ram_req.waddr = idx_reg[ADDR_W-1:0];
                    ram_req.wdata = {rd_ent, ticks_t'(rd_tk - sub)};
                end
                default:
                begin
                    ram_req.we = 1'b0;
                end
            endcase
        end
    end

    // Sequencer state, walk registers and result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= MODE_INSERT;
            id_reg         <= '0;
            tk_reg         <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            adv_reg        <= '0;
            held_reg       <= '0;
            res_head_reg   <= '0;
            res_adv_reg    <= '0;
            res_status_reg <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_head_reg   <= '0;
            rsp_adv_reg    <= '0;
            rsp_status_reg <= ST_OK;
            rsp_count_reg  <= '0;
        end
        else
        begin
            // Drop the result beat once taken, unless a new one loads now
            if (rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        op_reg       <= cmd.mode;
                        id_reg       <= cmd.entity_id;
                        tk_reg       <= cmd.ticks;
                        found_reg    <= 1'b0;
                        res_head_reg <= '0;
                        res_adv_reg  <= '0;
                        unique case (cmd.mode)
                            MODE_INSERT:
                            begin
                                if (held_reg == held_t'(QUEUE_DEPTH))
                                begin
                                    idx_reg        <= '0;
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg        <= held_reg;
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_READ;
                                end
                            end
                            MODE_REMOVE:
                            begin
                                idx_reg <= '0;
                                if (held_reg == '0)
                                begin
                                    res_status_reg <= ST_NOT_FOUND;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_READ;
                                end
                            end
                            MODE_POP, MODE_PEEK, MODE_ADVANCE:
                            begin
                                idx_reg <= '0;
                                if (held_reg == '0)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_READ;
                                end
                            end
                            default:
                            begin
                                idx_reg        <= '0;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end

                S_READ:
                begin
                    // Insert that reached the head writes the new entry at slot 0
                    if ((op_reg == MODE_INSERT) && idx_zero)
                    begin
                        held_reg  <= held_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    unique case (op_reg)
                        MODE_INSERT:
                        begin
                            if (rd_tk > tk_reg)
                            begin
                                idx_reg   <= idx_dec;
                                state_reg <= S_READ;
                            end
                            else
                            begin
                                held_reg  <= held_reg + 1'b1;
                                state_reg <= S_DONE;
                            end
                        end
                        MODE_REMOVE, MODE_POP:
                        begin
                            if ((op_reg == MODE_POP) && idx_zero && (rd_tk != '0))
                            begin
                                res_status_reg <= ST_NOT_DUE;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                if (hit)
                                begin
                                    found_reg <= 1'b1;
                                    if (op_reg == MODE_POP)
                                    begin
                                        res_head_reg <= rd_ent;
                                    end
                                end
                                if (last)
                                begin
                                    if (found_reg || hit)
                                    begin
                                        held_reg <= held_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        res_status_reg <= ST_NOT_FOUND;
                                    end
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg   <= idx_inc;
                                    state_reg <= S_READ;
                                end
                            end
                        end
                        MODE_PEEK:
                        begin
                            res_head_reg <= rd_ent;
                            state_reg    <= S_DONE;
                        end
                        MODE_ADVANCE:
                        begin
                            if (idx_zero)
                            begin
                                adv_reg     <= rd_tk;
                                res_adv_reg <= rd_tk;
                            end
                            if (last || (idx_zero && (rd_tk == '0)))
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= idx_inc;
                                state_reg <= S_READ;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_DONE:
                begin
                    // Hand the result to the beat register once it is free
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_head_reg   <= res_head_reg;
                        rsp_adv_reg    <= res_adv_reg;
                        rsp_status_reg <= res_status_reg;
                        rsp_count_reg  <= count_t'(held_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.head_entity    = rsp_head_reg;
    assign rsp.advanced_ticks = rsp_adv_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.entry_count    = rsp_count_reg;

endmodule

// File: rtl/core/ticks_ordered_turn_queue.sv
// ---------------------------------------------------------------------------
// Ticks-ordered turn queue
// Sorted priority queue of entity ids keyed by ticks-to-act, kept in a
// single-port-pair slot RAM and updated by a read/modify/write sequencer.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------------
//  cmd     | in  | valid / ready | mode, entity_id, ticks
//  rsp     | out | valid / ready | head_entity, advanced_ticks, status, entry_count
//
// Each operation walks the slot RAM one entry at a time: a read state, then
// an evaluate state that may write back, as the RAM's read port is registered.
// One operation is in flight at a time; a new beat is taken while the last
// result waits.
// Reset clears the count only; slots are never read before being written.
// ---------------------------------------------------------------------------
module ticks_ordered_turn_queue (
    input  logic        clk,
    input  logic        rst_n,
    totq_cmd_if.sink    cmd,
    totq_rsp_if.source  rsp
);

    import totq_pkg::*;

    ram_req_t ram_req;
    entry_t   ram_rdata;

    // Operation sequencer and result register
    totq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Sorted slot store: entity id over ticks
    totq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// File: sim/ticks_ordered_turn_queue_tb.sv
// ---------------------------------------------------------------------------
// Turn queue testbench
// Drives operation beats into the ticks-ordered turn queue and checks every
// result beat against a cycle-free model of the sorted store. A directed
// opening covers the empty, not-found and not-due paths and the
// reserved modes. Random traffic then fills the queue and drains it again,
// under three idling patterns on the two channels.
// ---------------------------------------------------------------------------
module ticks_ordered_turn_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import totq_pkg::*;

    // Reserved operation codes, which the block answers with OK and no change
    localparam mode_t MODE_RSVD_FIRST = MODE_ADVANCE + 3'd1;
    localparam mode_t MODE_RSVD_LAST  = '1;

    localparam int RANDOM_ITEMS = 1926;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 64;

    typedef struct packed {
        id_t     head_entity;
        ticks_t  advanced_ticks;
        status_t status;
        count_t  entry_count;
    } turn_result_t;

    // Sorted store model plus the queue of results still to arrive
    class turn_queue_scoreboard;
        id_t          slot_id[QUEUE_DEPTH];
        ticks_t       slot_due[QUEUE_DEPTH];
        int           held;
        turn_result_t expected_turns[$];
        int           failures;
        int           ops_seen;
        int           results_seen;
        int           full_hits;
        int           absent_hits;
        int           empty_hits;
        int           not_due_hits;
        int           pops_done;

        function new();
            foreach (slot_id[k])
            begin
                slot_id[k]  = '0;
                slot_due[k] = '0;
            end
            held = 0;
            failures = 0;
            ops_seen = 0;
            results_seen = 0;
            full_hits = 0;
            absent_hits = 0;
            empty_hits = 0;
            not_due_hits = 0;
            pops_done = 0;
        endfunction

        function int held_count();
            return held;
        endfunction

        function id_t entity_at(int pos);
            return slot_id[pos];
        endfunction

        function int pending();
            return expected_turns.size();
        endfunction

        // Close the gap left by a deleted slot
        function void drop_slot(int pos);
            for (int k = pos; k + 1 < held; k++)
            begin
                slot_id[k]  = slot_id[k + 1];
                slot_due[k] = slot_due[k + 1];
            end
            held--;
        endfunction

        function turn_result_t predict_turn(mode_t m, id_t id, ticks_t t);
            turn_result_t res;
            int           pos;
            ticks_t       step;
            res = '0;
            case (m)
                MODE_INSERT:
                begin
                    if (held >= QUEUE_DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        // Land after every entry that is not later
                        pos = 0;
                        while (pos < held && slot_due[pos] <= t)
                            pos++;
                        for (int k = held; k > pos; k--)
                        begin
                            slot_id[k]  = slot_id[k - 1];
                            slot_due[k] = slot_due[k - 1];
                        end
                        slot_id[pos]  = id;
                        slot_due[pos] = t;
                        held++;
                    end
                end
                MODE_REMOVE:
                begin
                    pos = -1;
                    for (int k = 0; k < held; k++)
                        if (pos < 0 && slot_id[k] == id)
                            pos = k;
                    if (pos < 0)
                        res.status = ST_NOT_FOUND;
                    else
                        drop_slot(pos);
                end
                MODE_POP:
                begin
                    if (held == 0)
                        res.status = ST_EMPTY;
                    else if (slot_due[0] != '0)
                        res.status = ST_NOT_DUE;
                    else
                    begin
                        res.head_entity = slot_id[0];
                        drop_slot(0);
                    end
                end
                MODE_PEEK:
                begin
                    if (held == 0)
                        res.status = ST_EMPTY;
                    else
                        res.head_entity = slot_id[0];
                end
                MODE_ADVANCE:
                begin
                    if (held == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        // Head holds the minimum, so nothing wraps
                        step = slot_due[0];
                        for (int k = 0; k < held; k++)
                            slot_due[k] = slot_due[k] - step;
                        res.advanced_ticks = step;
                    end
                end
                default: ;
            endcase
            res.entry_count = count_t'(held);
            return res;
        endfunction

        function void note_command(mode_t m, id_t id, ticks_t t);
            turn_result_t res;
            res = predict_turn(m, id, t);
            ops_seen++;
            case (res.status)
                ST_FULL:      full_hits++;
                ST_NOT_FOUND: absent_hits++;
                ST_EMPTY:     empty_hits++;
                ST_NOT_DUE:   not_due_hits++;
                default:      if (m == MODE_POP) pops_done++;
            endcase
            expected_turns.push_back(res);
        endfunction

        function void check_result(id_t head, ticks_t adv, status_t st, count_t cnt);
            turn_result_t want;
            results_seen++;
            if (expected_turns.size() == 0)
            begin
                $error("result beat with no operation waiting");
                failures++;
                return;
            end
            want = expected_turns.pop_front();
            if (head !== want.head_entity)
            begin
                $error("head_entity: expected %0h, got %0h", want.head_entity, head);
                failures++;
            end
            if (adv !== want.advanced_ticks)
            begin
                $error("advanced_ticks: expected %0h, got %0h", want.advanced_ticks, adv);
                failures++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                failures++;
            end
            if (cnt !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
                failures++;
            end
        endfunction

        function void flag_leftovers();
            if (expected_turns.size() != 0)
            begin
                $error("%0d results never arrived", expected_turns.size());
                failures += expected_turns.size();
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    bit   filling;

    turn_queue_scoreboard queue_sb;

    totq_cmd_if cmd_ch();
    totq_rsp_if rsp_ch();

    ticks_ordered_turn_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // Record accepted operations and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            queue_sb.check_result(rsp_ch.head_entity, rsp_ch.advanced_ticks,
                                  rsp_ch.status, rsp_ch.entry_count);
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            queue_sb.note_command(cmd_ch.mode, cmd_ch.entity_id, cmd_ch.ticks);
    end

    // Present one operation beat and hold it until taken
    task automatic send_op(input mode_t m, input id_t id, input ticks_t t);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.mode      <= m;
        cmd_ch.entity_id <= id;
        cmd_ch.ticks     <= t;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Hold off the sender until every result is back
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (queue_sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic id_t random_id();
        if ($urandom_range(0, 9) < 6)
            return id_t'($urandom_range(0, 15));
        return id_t'($urandom_range(0, 65535));
    endfunction

    function automatic ticks_t random_ticks();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ticks_t'($urandom_range(0, 7));
            5, 6, 7:       return ticks_t'($urandom_range(0, 255));
            8:             return $urandom_range(0, 1) ? '1 : '0;
            default:       return ticks_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Pick one operation: fill toward full, then drain toward empty
    task automatic random_op();
        int     held;
        int     r;
        mode_t  m;
        id_t    id;
        ticks_t t;
        held = queue_sb.held_count();
        if (held == 0)
            filling = 1'b1;
        else if (held == QUEUE_DEPTH && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        id = random_id();
        t  = random_ticks();
        r  = $urandom_range(0, 99);
        if (r < 3)
            m = mode_t'(int'(MODE_RSVD_FIRST) +
                        $urandom_range(0, int'(MODE_RSVD_LAST) - int'(MODE_RSVD_FIRST)));
        else if (r < (filling ? 60 : 18))
            m = MODE_INSERT;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                m = MODE_REMOVE;
                if (held > 0 && $urandom_range(0, 3) != 0)
                    id = queue_sb.entity_at($urandom_range(0, held - 1));
            end
            else if (r < 60)
                m = MODE_POP;
            else if (r < 85)
                m = MODE_ADVANCE;
            else
                m = MODE_PEEK;
        end
        send_op(m, id, t);
    endtask

    // Give up on a hung run
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        queue_sb          = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        filling           = 1'b1;
        sender_idle_pct   = 33;
        receiver_idle_pct = 63;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = MODE_PEEK;
        cmd_ch.entity_id  = '0;
        cmd_ch.ticks      = '0;
        rsp_ch.ready      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Empty queue, absent id and the reserved modes
        send_op(MODE_PEEK, '0, '0);
        send_op(MODE_POP, '1, '1);
        send_op(MODE_ADVANCE, '0, '0);
        send_op(MODE_REMOVE, '0, '0);
        for (int k = int'(MODE_RSVD_FIRST); k <= int'(MODE_RSVD_LAST); k++)
            send_op(mode_t'(k), '1, '1);

        // Extremes, equal ticks in arrival order, due and not-due heads
        send_op(MODE_INSERT, 16'h1234, 16'd5);
        send_op(MODE_INSERT, '0, 16'd5);
        send_op(MODE_INSERT, '1, '1);
        send_op(MODE_INSERT, 16'h00AA, '0);
        send_op(MODE_PEEK, '0, '0);
        send_op(MODE_POP, '0, '0);
        send_op(MODE_POP, '0, '0);
        send_op(MODE_ADVANCE, '0, '0);
        send_op(MODE_POP, '0, '0);
        send_op(MODE_REMOVE, '1, '0);
        send_op(MODE_REMOVE, 16'hBEEF, '0);
        send_op(MODE_PEEK, '0, '0);
        send_op(MODE_ADVANCE, '0, '0);
        send_op(MODE_POP, '0, '0);
        send_op(MODE_ADVANCE, '1, '1);
        wait_drained();

        // Random traffic under three idling patterns
        for (int k = 0; k < RANDOM_ITEMS / 3; k++)
            random_op();
        wait_drained();
        sender_idle_pct   = 63;
        receiver_idle_pct = 33;
        for (int k = 0; k < RANDOM_ITEMS / 3; k++)
            random_op();
        wait_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        for (int k = 0; k < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); k++)
            random_op();

        // Drop valid, let the last results land, then settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        queue_sb.flag_leftovers();

        $display("Ran %0d operations and checked %0d results.",
                 queue_sb.ops_seen, queue_sb.results_seen);
        $display("Full %0d, not found %0d, empty %0d, head not due %0d, pops %0d.",
                 queue_sb.full_hits, queue_sb.absent_hits, queue_sb.empty_hits,
                 queue_sb.not_due_hits, queue_sb.pops_done);
        if (queue_sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
